FILE: design/knr_pkg.sv
// Shared types and constants for the k-mer neighbor and reverse-complement block.
`default_nettype none

package knr_pkg;

    // Number of 64-bit words that carry bases (1 or 2).
    localparam int KMER_WORDS = 2;
    // Port-side k-mer width and base count are fixed at two words.
    localparam int KMER_BITS  = 128;
    localparam int BASES      = KMER_BITS / 2;
    localparam int MAX_K      = 32 * KMER_WORDS;
    localparam int LEN_W      = 7;
    localparam int SHIFT_W    = 8;
    localparam int MASK_W     = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_KMER_LENGTH = 2'd0;
    localparam logic [1:0] REG_COLOR_SPACE = 2'd1;

    typedef enum logic [1:0] {
        ACT_EDGES   = 2'd0,
        ACT_REVCOMP = 2'd1,
        ACT_CANON   = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DIR_PRE  = 2'd0,
        DIR_SUC  = 2'd1,
        DIR_NONE = 2'd2
    } direction_t;

    // Item as it enters the pipeline, with the length already clamped.
    typedef struct packed {
        action_t                action;
        logic [KMER_BITS-1:0]   kmer;
        logic [MASK_W-1:0]      edge_mask;
        logic [LEN_W-1:0]       klen;
        logic                   color_space;
    } in_item_t;

    // Item handed to the emit stage: everything needed for all its results.
    typedef struct packed {
        logic                   is_edge;
        logic [MASK_W-1:0]      pending;
        logic [KMER_BITS-1:0]   pre;
        logic [KMER_BITS-1:0]   suc;
        logic [KMER_BITS-1:0]   spos;
        logic [KMER_BITS-1:0]   single;
    } res_item_t;

endpackage

`default_nettype wire

FILE: design/knr_front.sv
// Three-stage front pipeline: input register, reverse complement with neighbor bases, canonical compare.
`default_nettype none

module knr_front
    import knr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output res_item_t      out_item
);

    typedef struct packed {
        action_t                action;
        logic [KMER_BITS-1:0]   kmer;
        logic [MASK_W-1:0]      edge_mask;
        logic [KMER_BITS-1:0]   rc;
        logic [KMER_BITS-1:0]   pre;
        logic [KMER_BITS-1:0]   suc;
        logic [KMER_BITS-1:0]   spos;
    } s2_t;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic       s1_ready, s2_ready, s3_ready;
    logic       in_useful;
    in_item_t   s1_reg;
    s2_t        s2_next, s2_reg;
    res_item_t  s3_next, s3_reg;

    logic [KMER_BITS-1:0] rev_full;
    logic [SHIFT_W-1:0]   rc_shift;
    logic [SHIFT_W-1:0]   len2;
    logic [KMER_BITS-1:0] clr_mask;
    logic                 kmer_less;

    // Stall chain: a stage advances when the one after it is empty or moving
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Drop items that cause no result right at the entry
    assign in_useful = (in_item.action == ACT_REVCOMP) || (in_item.action == ACT_CANON)
                    || ((in_item.action == ACT_EDGES) && (in_item.edge_mask != '0));

    // Stage 1: register the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid && in_useful;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= in_item;
        end
    end

    // Stage 2: reverse all bases, complement unless color space, align to k
    always_comb
    begin
        for (int p = 0; p < BASES; p++)
        begin
            rev_full[2*p +: 2] = s1_reg.kmer[2*(BASES-1-p) +: 2]
                               ^ {2{!s1_reg.color_space}};
        end
    end

    assign rc_shift = {LEN_W'(BASES) - s1_reg.klen, 1'b0};
    assign len2     = {s1_reg.klen, 1'b0};
    assign clr_mask = (s1_reg.klen < LEN_W'(MAX_K))
                    ? (KMER_BITS'(2'b11) << len2) : '0;

    // Stage 2: predecessor base, successor base and successor code position
    always_comb
    begin
        s2_next.action    = s1_reg.action;
        s2_next.kmer      = s1_reg.kmer;
        s2_next.edge_mask = s1_reg.edge_mask;
        s2_next.rc        = rev_full >> rc_shift;
        s2_next.pre       = (s1_reg.kmer << 2) & ~clr_mask;
        if (KMER_WORDS < 2)
        begin
            s2_next.pre[KMER_BITS-1:KMER_BITS/2] = '0;
        end
        s2_next.suc       = s1_reg.kmer >> 2;
        s2_next.spos      = KMER_BITS'(2'b11) << (len2 - SHIFT_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: canonical compare, word 0 ranks first
    assign kmer_less = (s2_reg.kmer[63:0] < s2_reg.rc[63:0])
                    || ((s2_reg.kmer[63:0] == s2_reg.rc[63:0])
                        && (s2_reg.kmer[127:64] < s2_reg.rc[127:64]));

    always_comb
    begin
        s3_next.is_edge = (s2_reg.action == ACT_EDGES);
        s3_next.pending = (s2_reg.action == ACT_EDGES) ? s2_reg.edge_mask : MASK_W'(1);
        s3_next.pre     = s2_reg.pre;
        s3_next.suc     = s2_reg.suc;
        s3_next.spos    = s2_reg.spos;
        s3_next.single  = ((s2_reg.action == ACT_CANON) && kmer_less)
                        ? s2_reg.kmer : s2_reg.rc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_reg;

    // Every item reaching the emit side causes at least one result
    a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_reg.pending != '0))
        else $error("front item without pending results");

    // A stalled last stage keeps its item
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_ready) |=> (s3_valid_reg && $stable(s3_reg)))
        else $error("stalled front item lost or changed");

endmodule

`default_nettype wire

FILE: design/knr_emit.sv
// Emit stage: walks the pending result bits of one item and feeds the output register.
`default_nettype none

module knr_emit
    import knr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire res_item_t  in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [KMER_BITS-1:0] out_kmer,
    output direction_t      out_direction,
    output logic [1:0]      out_code,
    output logic            out_last
);

    logic                  hold_valid_reg;
    res_item_t             hold_reg;
    logic [MASK_W-1:0]     rem_next;
    logic [2:0]            pick;
    logic                  pick_last;
    logic                  out_load;
    logic                  step;

    logic                  m_valid_reg;
    logic [KMER_BITS-1:0]  m_kmer_reg, m_kmer_next;
    direction_t            m_dir_reg, m_dir_next;
    logic [1:0]            m_code_reg, m_code_next;
    logic                  m_last_reg;

    // Lowest pending result goes first: predecessors, then successors
    always_comb
    begin
        pick = 3'd0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (hold_reg.pending[i])
            begin
                pick = 3'(i);
            end
        end
        rem_next  = hold_reg.pending & ~(MASK_W'(1) << pick);
        pick_last = (rem_next == '0);
    end

    // Build the picked result
    always_comb
    begin
        if (!hold_reg.is_edge)
        begin
            m_kmer_next = hold_reg.single;
            m_dir_next  = DIR_NONE;
            m_code_next = 2'd0;
        end
        else if (!pick[2])
        begin
            m_kmer_next = hold_reg.pre | KMER_BITS'(pick[1:0]);
            m_dir_next  = DIR_PRE;
            m_code_next = pick[1:0];
        end
        else
        begin
            m_kmer_next = hold_reg.suc | (hold_reg.spos & {(KMER_BITS/2){pick[1:0]}});
            m_dir_next  = DIR_SUC;
            m_code_next = pick[1:0];
        end
    end

    assign out_load = !m_valid_reg || out_ready;
    assign step     = hold_valid_reg && out_load;
    assign in_ready = !hold_valid_reg || (step && pick_last);

    // Hold the item until its last result has moved to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg <= in_item;
        end
        else if (step)
        begin
            hold_reg.pending <= rem_next;
        end
    end

    // Output register: loads whenever empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_kmer_reg <= m_kmer_next;
            m_dir_reg  <= m_dir_next;
            m_code_reg <= m_code_next;
            m_last_reg <= pick_last;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_kmer      = m_kmer_reg;
    assign out_direction = m_dir_reg;
    assign out_code      = m_code_reg;
    assign out_last      = m_last_reg;

    // A held item always has something left to send
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (hold_reg.pending != '0))
        else $error("held item with nothing pending");

    // Reverse complement and canonical items give a single result
    a_single_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !hold_reg.is_edge) |-> $onehot(hold_reg.pending))
        else $error("non-edge item with several pending results");

    // Non-edge results close their item and carry no code
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_dir_reg == DIR_NONE)) |-> (m_last_reg && (m_code_reg == 2'd0)))
        else $error("non-edge result not last or with a code");

endmodule

`default_nettype wire

FILE: design/kmer_neighbor_and_revcomp.sv
// Top level of the k-mer neighbor expansion and reverse-complement block.
//
// Usage:
//   s_* channel takes one item: s_tuser holds the action (0 expand edges,
//   1 reverse complement, 2 canonical form), s_tdata the two k-mer words and
//   the edge mask. m_* channel gives the results, m_tlast on the final result
//   of an item. Action 3 and an edge item with an empty mask are accepted and
//   give nothing.
//   cfg_we/cfg_index/cfg_data write kmer_length (index 0) and color_space
//   (index 1); write them only while no item is in flight.
//   Results pass the three front stages, the emit hold and output registers.
//   Reverse complement and canonical items flow at one per cycle while
//   m_tready is high; an edge item holds the emit stage for one result per
//   set mask bit (1 to 8); the single output register sends one per cycle.
//   Reset clears all valid bits and sets kmer_length 31, color_space 0.
//   When m_tready is low the output register holds, the emit stage and the
//   three front stages fill up, then s_tready drops; nothing is lost.
`default_nettype none

module kmer_neighbor_and_revcomp
    import knr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // item in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // kmer_word0, kmer_word1, edge_mask
    input  wire logic [1:0]   s_tuser,   // action
    // result out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // result_word0, result_word1, added_code, zero pad
    output logic [1:0]        m_tuser,   // direction
    output logic              m_tlast,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [6:0]   cfg_data
);

    logic [LEN_W-1:0]     kmer_length_reg;
    logic                 color_space_reg;
    logic [LEN_W-1:0]     klen_eff;
    in_item_t             in_item;
    logic                 f_valid, f_ready;
    res_item_t            f_item;
    logic [KMER_BITS-1:0] r_kmer;
    direction_t           r_dir;
    logic [1:0]           r_code;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= LEN_W'(31);
            color_space_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KMER_LENGTH: kmer_length_reg <= cfg_data[LEN_W-1:0];
                REG_COLOR_SPACE: color_space_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp length to 1..MAX_K
    assign klen_eff = (kmer_length_reg == '0) ? LEN_W'(1)
                    : (kmer_length_reg > LEN_W'(MAX_K)) ? LEN_W'(MAX_K)
                    : kmer_length_reg;

    // Unpack the input item
    always_comb
    begin
        in_item.action      = action_t'(s_tuser);
        in_item.kmer[63:0]  = s_tdata[63:0];
        in_item.kmer[127:64] = (KMER_WORDS >= 2) ? s_tdata[127:64] : 64'd0;
        in_item.edge_mask   = s_tdata[135:128];
        in_item.klen        = klen_eff;
        in_item.color_space = color_space_reg;
    end

    knr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    knr_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (f_valid),
        .in_ready      (f_ready),
        .in_item       (f_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kmer      (r_kmer),
        .out_direction (r_dir),
        .out_code      (r_code),
        .out_last      (m_tlast)
    );

    // Pack the result item
    assign m_tdata = {6'd0, r_code, r_kmer};
    assign m_tuser = r_dir;

endmodule

`default_nettype wire
